>>> hdl/rlcf_pkg.sv
// Shared types, constants, microcode control word and the quarter-wave sine table.
`default_nettype none

package rlcf_pkg;

	// Value and coefficient formats
	localparam int VALUE_W = 32;               // signed Q16.16 values
	localparam int COEF_W  = 32;               // unsigned Q2.30 coefficients
	localparam int OPA_W   = VALUE_W + 1;      // difference of two values
	localparam int PROD_W  = VALUE_W + COEF_W; // magnitude times coefficient
	localparam int ACC_W   = 50;               // largest scaled product plus a difference
	localparam int REG31_W = 31;               // peak voltage and resistance registers

	localparam logic signed [ACC_W-1:0] V_MAX = (ACC_W'(1) <<< (VALUE_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] V_MIN = -V_MAX - ACC_W'(1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_PEAK      = 3'd0,
		REG_PHASE_STEP       = 3'd1,
		REG_INPUT_DECAY      = 3'd2,
		REG_INPUT_GAIN       = 3'd3,
		REG_CAP_GAIN         = 3'd4,
		REG_LOAD_DECAY       = 3'd5,
		REG_LOAD_GAIN        = 3'd6,
		REG_INPUT_RESISTANCE = 3'd7
	} reg_idx_t;

	// Sine table
	localparam int SINE_ENTRIES = 1024;
	localparam int SINE_W       = 17;
	localparam int SINE_ADDR_W  = $clog2(SINE_ENTRIES + 1);
	localparam int PHASE_W      = 32;
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SINE_FULL   = 64'd131071;
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	typedef logic [SINE_W-1:0] sine_rom_t [SINE_ENTRIES + 1];

	// Horner Taylor series to x^13 in Q30, one entry per quarter-wave step,
	// plus the mirrored peak entry at the end.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] e;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			x  = (HALF_PI_Q30 * 64'(k)) / SINE_ENTRIES;
			x2 = (x * x) >> 30;
			t  = Q30_ONE;
			for (int d = 0; d < 6; d++) begin
				t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DIV[d];
			end
			s = (x * t) >> 30;
			e = (s * SINE_FULL + (64'd1 << 29)) >> 30;
			if (e > SINE_FULL) begin
				e = SINE_FULL;
			end
			rom[k] = e[SINE_W-1:0];
		end
		rom[SINE_ENTRIES] = SINE_FULL[SINE_W-1:0];
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// Microcode fields
	typedef enum logic [1:0] {
		COND_NEXT,
		COND_NO_ITEM,
		COND_OUT_FULL,
		COND_ALWAYS
	} cond_t;

	typedef enum logic [2:0] {
		OPA_SINE,
		OPA_IIN,
		OPA_DRIVE,
		OPA_DIN,
		OPA_IC,
		OPA_ILOAD,
		OPA_VNEW
	} opa_t;

	typedef enum logic [2:0] {
		CF_PEAK,
		CF_IN_DECAY,
		CF_IN_GAIN,
		CF_RES,
		CF_CAP_GAIN,
		CF_LD_DECAY,
		CF_LD_GAIN
	} coef_t;

	typedef enum logic [1:0] {
		SH_16,
		SH_17,
		SH_30
	} shift_t;

	typedef enum logic [2:0] {
		SRC_ACC,
		SRC_ZERO,
		SRC_IIN,
		SRC_DRIVE,
		SRC_VCAP,
		SRC_ILOAD,
		SRC_ICDIFF
	} src_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_VS,
		DST_INEW,
		DST_IC,
		DST_VLI,
		DST_VNEW,
		DST_ILNEW
	} dst_t;

	localparam int PC_W = 4;

	typedef struct packed {
		logic   en;
		shift_t sh;
		logic   sub;
	} mul_op_t;

	typedef struct packed {
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            rom_rd;
		logic            ph_adv;
		mul_op_t         mul;
		opa_t            opa;
		coef_t           coef;
		logic            acc_en;
		src_t            src;
		logic            add_term;
		dst_t            dst;
		logic            commit;
	} ctrl_t;

	localparam ctrl_t CTRL_NOP = '{
		cond:     COND_NEXT,
		target:   '0,
		rom_rd:   1'b0,
		ph_adv:   1'b0,
		mul:      '{en: 1'b0, sh: SH_30, sub: 1'b0},
		opa:      OPA_SINE,
		coef:     CF_PEAK,
		acc_en:   1'b0,
		src:      SRC_ACC,
		add_term: 1'b0,
		dst:      DST_NONE,
		commit:   1'b0
	};

endpackage

`default_nettype wire

>>> hdl/rlc_filter_euler_step.sv
// Top level of the forward-Euler RLC filter step: registers, sine table, datapath and ports.
`default_nettype none

// One accepted word on the input channel advances the filter by one time step:
// the source sample is read from a quarter-wave sine table at the current
// phase, the phase advances by phase_step, and the input inductor current, the
// capacitor voltage and the load current are updated in that order. A word
// with restart set clears phase and the three state values first; the
// configuration registers and the table are kept. All values are signed
// Q16.16 and saturate to 32 bits; saturated reports any clip in that step.
// A new word is taken only after the previous step has run to its end; each
// step runs a fifteen-step microprogram that passes seven products through one
// shared 32x32 multiplier with a two-register product and rounding pipeline.
// The input side is stalled while a step is in flight; a finished result
// waits in the output register while the next word is already being worked
// on, and only the step before the last holds if that register has not been
// drained. Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata; the user must do so only while the block is idle, which the
// block itself does not enforce. They reset to zero. The sine table is a
// constant ROM of SINE_ENTRIES + 1 entries and needs no fill after reset.
module rlc_filter_euler_step import rlcf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [COEF_W-1:0]         cfg_wdata,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      restart,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] source_voltage,
	output logic signed [VALUE_W-1:0] inductor_voltage,
	output logic signed [VALUE_W-1:0] load_voltage,
	output logic signed [VALUE_W-1:0] cap_voltage,
	output logic signed [VALUE_W-1:0] input_current,
	output logic signed [VALUE_W-1:0] load_current,
	output logic signed [VALUE_W-1:0] cap_current,
	output logic                      saturated
);

	// configuration registers
	logic [REG31_W-1:0] source_peak_q;
	logic [PHASE_W-1:0] phase_step_q;
	logic [COEF_W-1:0]  input_decay_q;
	logic [COEF_W-1:0]  input_gain_q;
	logic [COEF_W-1:0]  cap_gain_q;
	logic [COEF_W-1:0]  load_decay_q;
	logic [COEF_W-1:0]  load_gain_q;
	logic [REG31_W-1:0] input_res_q;

	// filter state
	logic [PHASE_W-1:0]        phase_q;
	logic signed [VALUE_W-1:0] i_in_q;
	logic signed [VALUE_W-1:0] v_cap_q;
	logic signed [VALUE_W-1:0] i_load_q;

	// working registers of one step
	logic [SINE_W-1:0]         sine_q;
	logic                      sine_neg_q;
	logic signed [VALUE_W-1:0] vs_q;
	logic signed [VALUE_W-1:0] i_new_q;
	logic signed [VALUE_W-1:0] ic_q;
	logic signed [VALUE_W-1:0] vli_q;
	logic signed [VALUE_W-1:0] v_new_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      clip_q;

	// output word
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_vs_q;
	logic signed [VALUE_W-1:0] out_vli_q;
	logic signed [VALUE_W-1:0] out_vcap_q;
	logic signed [VALUE_W-1:0] out_iin_q;
	logic signed [VALUE_W-1:0] out_iload_q;
	logic signed [VALUE_W-1:0] out_ic_q;
	logic                      out_sat_q;

	ctrl_t                     ctrl;
	logic                      seq_idle;
	logic                      in_accept;
	logic                      out_full;

	logic [30+SINE_ADDR_W-1:0] idx_prod;
	logic [SINE_ADDR_W-1:0]    idx;
	logic [SINE_ADDR_W-1:0]    rom_addr;

	logic signed [OPA_W-1:0]   drive;
	logic signed [OPA_W-1:0]   din;
	logic signed [OPA_W-1:0]   icdiff;
	logic signed [OPA_W-1:0]   sine_val;
	logic signed [OPA_W-1:0]   opa;
	logic [COEF_W-1:0]         coef;
	logic signed [ACC_W-1:0]   term;

	logic signed [ACC_W-1:0]   base;
	logic signed [ACC_W-1:0]   sum;
	logic signed [VALUE_W-1:0] sat_val;
	logic                      clip;
	logic                      wr;

	assign in_stall  = !seq_idle;
	assign in_accept = in_valid && !in_stall;
	assign out_full  = out_valid_q && out_stall;

	rlcf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_full (out_full),
		.ctrl     (ctrl),
		.idle     (seq_idle)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_peak_q <= '0;
			phase_step_q  <= '0;
			input_decay_q <= '0;
			input_gain_q  <= '0;
			cap_gain_q    <= '0;
			load_decay_q  <= '0;
			load_gain_q   <= '0;
			input_res_q   <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SOURCE_PEAK:      source_peak_q <= cfg_wdata[REG31_W-1:0];
				REG_PHASE_STEP:       phase_step_q  <= cfg_wdata;
				REG_INPUT_DECAY:      input_decay_q <= cfg_wdata;
				REG_INPUT_GAIN:       input_gain_q  <= cfg_wdata;
				REG_CAP_GAIN:         cap_gain_q    <= cfg_wdata;
				REG_LOAD_DECAY:       load_decay_q  <= cfg_wdata;
				REG_LOAD_GAIN:        load_gain_q   <= cfg_wdata;
				REG_INPUT_RESISTANCE: input_res_q   <= cfg_wdata[REG31_W-1:0];
				default: ;
			endcase
		end
	end

	// Sine lookup: low 30 phase bits pick the entry, bit 30 mirrors the
	// quarter wave, bit 31 negates.
	always_comb begin
		idx_prod = (30 + SINE_ADDR_W)'(phase_q[29:0]) * (30 + SINE_ADDR_W)'(SINE_ENTRIES);
		idx      = idx_prod[30+SINE_ADDR_W-1:30];
		rom_addr = phase_q[30] ? SINE_ADDR_W'(SINE_ENTRIES) - idx : idx;
	end

	always_ff @(posedge clk) begin
		if (ctrl.rom_rd) begin
			sine_q     <= SINE_ROM[rom_addr];
			sine_neg_q <= phase_q[31];
		end
	end

	// differences feeding the multiplier and the accumulator
	always_comb begin
		drive    = OPA_W'(vs_q) - OPA_W'(v_cap_q);
		din      = OPA_W'(i_new_q) - OPA_W'(i_in_q);
		icdiff   = OPA_W'(i_new_q) - OPA_W'(i_load_q);
		sine_val = sine_neg_q ? -signed'(OPA_W'(sine_q)) : signed'(OPA_W'(sine_q));
	end

	// multiplier operand selection
	always_comb begin
		case (ctrl.opa)
			OPA_SINE:  opa = sine_val;
			OPA_IIN:   opa = OPA_W'(i_in_q);
			OPA_DRIVE: opa = drive;
			OPA_DIN:   opa = din;
			OPA_IC:    opa = OPA_W'(ic_q);
			OPA_ILOAD: opa = OPA_W'(i_load_q);
			OPA_VNEW:  opa = OPA_W'(v_new_q);
			default:   opa = '0;
		endcase
		case (ctrl.coef)
			CF_PEAK:     coef = COEF_W'(source_peak_q);
			CF_IN_DECAY: coef = input_decay_q;
			CF_IN_GAIN:  coef = input_gain_q;
			CF_RES:      coef = COEF_W'(input_res_q);
			CF_CAP_GAIN: coef = cap_gain_q;
			CF_LD_DECAY: coef = load_decay_q;
			CF_LD_GAIN:  coef = load_gain_q;
			default:     coef = '0;
		endcase
	end

	rlcf_mul u_mul (
		.clk  (clk),
		.op   (ctrl.mul),
		.opa  (opa),
		.coef (coef),
		.term (term)
	);

	// Accumulate: pick a base, add the rounded product, saturate on write.
	always_comb begin
		case (ctrl.src)
			SRC_ACC:    base = acc_q;
			SRC_ZERO:   base = '0;
			SRC_IIN:    base = ACC_W'(i_in_q);
			SRC_DRIVE:  base = ACC_W'(drive);
			SRC_VCAP:   base = ACC_W'(v_cap_q);
			SRC_ILOAD:  base = ACC_W'(i_load_q);
			SRC_ICDIFF: base = ACC_W'(icdiff);
			default:    base = '0;
		endcase
		sum = base + (ctrl.add_term ? term : ACC_W'(0));
		wr  = (ctrl.dst != DST_NONE);
		if (sum > V_MAX) begin
			sat_val = V_MAX[VALUE_W-1:0];
			clip    = 1'b1;
		end else if (sum < V_MIN) begin
			sat_val = V_MIN[VALUE_W-1:0];
			clip    = 1'b1;
		end else begin
			sat_val = sum[VALUE_W-1:0];
			clip    = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc_en) begin
			acc_q <= sum;
		end
		case (ctrl.dst)
			DST_VS:   vs_q    <= sat_val;
			DST_INEW: i_new_q <= sat_val;
			DST_IC:   ic_q    <= sat_val;
			DST_VLI:  vli_q   <= sat_val;
			DST_VNEW: v_new_q <= sat_val;
			default: ;
		endcase
	end

	// Filter state: clear on restart at accept, advance phase early in the
	// step, commit the new currents and voltage at the last step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			i_in_q   <= '0;
			v_cap_q  <= '0;
			i_load_q <= '0;
			clip_q   <= 1'b0;
		end else begin
			if (in_accept) begin
				clip_q <= 1'b0;
				if (restart) begin
					phase_q  <= '0;
					i_in_q   <= '0;
					v_cap_q  <= '0;
					i_load_q <= '0;
				end
			end else begin
				if (wr && clip) begin
					clip_q <= 1'b1;
				end
				if (ctrl.ph_adv) begin
					phase_q <= phase_q + phase_step_q;
				end
				if (ctrl.dst == DST_ILNEW) begin
					i_load_q <= sat_val;
				end
				if (ctrl.commit) begin
					i_in_q  <= i_new_q;
					v_cap_q <= v_new_q;
				end
			end
		end
	end

	// output word: load on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			out_vs_q    <= vs_q;
			out_vli_q   <= vli_q;
			out_vcap_q  <= v_new_q;
			out_iin_q   <= i_new_q;
			out_iload_q <= sat_val;
			out_ic_q    <= ic_q;
			out_sat_q   <= clip_q | (wr && clip);
		end
	end

	assign out_valid        = out_valid_q;
	assign source_voltage   = out_vs_q;
	assign inductor_voltage = out_vli_q;
	assign load_voltage     = out_vcap_q;
	assign cap_voltage      = out_vcap_q;
	assign input_current    = out_iin_q;
	assign load_current     = out_iload_q;
	assign cap_current      = out_ic_q;
	assign saturated        = out_sat_q;

	// a result is never written over a word still pending
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |-> !out_valid_q)
		else $error("commit while output word pending");

	// output valid only rises from a commit step
	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.commit))
		else $error("output valid without commit");

	// the sequencer leaves idle on every accepted word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("sequencer idle after accept");

	// restart clears the filter state before the step runs
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && restart) |=>
			(phase_q == '0 && i_in_q == '0 && v_cap_q == '0 && i_load_q == '0))
		else $error("restart did not clear state");

endmodule

`default_nettype wire

>>> hdl/rlcf_mul.sv
// Shared multiplier: magnitude times coefficient, then round half away and rescale.
`default_nettype none

module rlcf_mul import rlcf_pkg::*; (
	input  logic                    clk,
	input  mul_op_t                 op,
	input  logic signed [OPA_W-1:0] opa,
	input  logic [COEF_W-1:0]       coef,
	output logic signed [ACC_W-1:0] term
);

	logic [OPA_W-1:0]        abs_v;
	logic [VALUE_W-1:0]      mag;
	logic                    neg;
	logic [PROD_W-1:0]       prod_s1;
	logic                    neg_s1;
	shift_t                  sh_s1;
	logic [PROD_W:0]         rnd;
	logic [PROD_W:0]         shifted;
	logic [ACC_W-1:0]        r;
	logic signed [ACC_W-1:0] term_s2;

	// operand magnitude never exceeds VALUE_W bits
	always_comb begin
		neg   = opa[OPA_W-1];
		abs_v = neg ? -opa : opa;
		mag   = abs_v[VALUE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (op.en) begin
			prod_s1 <= PROD_W'(mag) * PROD_W'(coef);
			neg_s1  <= neg ^ op.sub;
			sh_s1   <= op.sh;
		end
	end

	always_comb begin
		case (sh_s1)
			SH_16: begin
				rnd     = {1'b0, prod_s1} + ((PROD_W + 1)'(1) << 15);
				shifted = rnd >> 16;
			end
			SH_17: begin
				rnd     = {1'b0, prod_s1} + ((PROD_W + 1)'(1) << 16);
				shifted = rnd >> 17;
			end
			default: begin
				rnd     = {1'b0, prod_s1} + ((PROD_W + 1)'(1) << 29);
				shifted = rnd >> 30;
			end
		endcase
		r = shifted[ACC_W-1:0];
	end

	always_ff @(posedge clk) begin
		term_s2 <= neg_s1 ? -signed'(r) : signed'(r);
	end

	assign term = term_s2;

endmodule

`default_nettype wire

>>> hdl/rlcf_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module rlcf_seq import rlcf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  out_full,
	output ctrl_t ctrl,
	output logic  idle
);

	localparam logic [PC_W-1:0] PC_IDLE = PC_W'(0);
	localparam logic [PC_W-1:0] PC_WAIT = PC_W'(13);

	logic [PC_W-1:0] pc_q;
	logic            take;

	// One control word per step; idle waits at step zero, step thirteen
	// holds while the output word is still pending.
	function automatic ctrl_t prog_word(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = CTRL_NOP;
		case (pc)
			4'd0: begin
				w.cond   = COND_NO_ITEM;
				w.target = PC_IDLE;
			end
			4'd1: begin
				w.rom_rd = 1'b1;
				w.ph_adv = 1'b1;
			end
			4'd2: begin
				w.mul  = '{en: 1'b1, sh: SH_17, sub: 1'b0};
				w.opa  = OPA_SINE;
				w.coef = CF_PEAK;
			end
			4'd3: begin
				w.mul  = '{en: 1'b1, sh: SH_30, sub: 1'b1};
				w.opa  = OPA_IIN;
				w.coef = CF_IN_DECAY;
			end
			4'd4: begin
				w.acc_en   = 1'b1;
				w.src      = SRC_ZERO;
				w.add_term = 1'b1;
				w.dst      = DST_VS;
			end
			4'd5: begin
				w.acc_en   = 1'b1;
				w.src      = SRC_IIN;
				w.add_term = 1'b1;
				w.mul      = '{en: 1'b1, sh: SH_30, sub: 1'b0};
				w.opa      = OPA_DRIVE;
				w.coef     = CF_IN_GAIN;
			end
			4'd6: begin
			end
			4'd7: begin
				w.acc_en   = 1'b1;
				w.src      = SRC_ACC;
				w.add_term = 1'b1;
				w.dst      = DST_INEW;
			end
			4'd8: begin
				w.mul    = '{en: 1'b1, sh: SH_16, sub: 1'b0};
				w.opa    = OPA_DIN;
				w.coef   = CF_RES;
				w.acc_en = 1'b1;
				w.src    = SRC_ICDIFF;
				w.dst    = DST_IC;
			end
			4'd9: begin
				w.mul  = '{en: 1'b1, sh: SH_30, sub: 1'b0};
				w.opa  = OPA_IC;
				w.coef = CF_CAP_GAIN;
			end
			4'd10: begin
				w.acc_en   = 1'b1;
				w.src      = SRC_DRIVE;
				w.add_term = 1'b1;
				w.dst      = DST_VLI;
				w.mul      = '{en: 1'b1, sh: SH_30, sub: 1'b1};
				w.opa      = OPA_ILOAD;
				w.coef     = CF_LD_DECAY;
			end
			4'd11: begin
				w.acc_en   = 1'b1;
				w.src      = SRC_VCAP;
				w.add_term = 1'b1;
				w.dst      = DST_VNEW;
			end
			4'd12: begin
				w.mul      = '{en: 1'b1, sh: SH_30, sub: 1'b0};
				w.opa      = OPA_VNEW;
				w.coef     = CF_LD_GAIN;
				w.acc_en   = 1'b1;
				w.src      = SRC_ILOAD;
				w.add_term = 1'b1;
			end
			4'd13: begin
				w.cond   = COND_OUT_FULL;
				w.target = PC_WAIT;
			end
			4'd14: begin
				w.acc_en   = 1'b1;
				w.src      = SRC_ACC;
				w.add_term = 1'b1;
				w.dst      = DST_ILNEW;
				w.commit   = 1'b1;
				w.cond     = COND_ALWAYS;
				w.target   = PC_IDLE;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

	assign ctrl = prog_word(pc_q);
	assign idle = (pc_q == PC_IDLE);

	always_comb begin
		case (ctrl.cond)
			COND_NO_ITEM:  take = !in_valid;
			COND_OUT_FULL: take = out_full;
			COND_ALWAYS:   take = 1'b1;
			default:       take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

endmodule

`default_nettype wire

>>> sim/tb_rlc_filter_euler_step.sv
// Self-checking testbench for the forward-Euler RLC filter step block.
`timescale 1ns / 1ps

module tb_rlc_filter_euler_step;
	import rlcf_pkg::*;

	// Run shape
	localparam int RANDOM_STEPS  = 1000;  // random words after the directed plan
	localparam int SETTLE_CYCLES = 20;    // wait after the last awaited result before a register write or the verdict
	localparam int HOLD_CYCLES   = 400;   // one long output hold-off to back up the block
	localparam int QUIET_LIMIT   = 3000;  // cycles without any handshake before giving up
	localparam int ERROR_PRINTS  = 50;

	// Fixed-point constants of the filter
	localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;  // pi/2 in Q30
	localparam logic [63:0] ONE_Q30          = 64'd1073741824;
	localparam longint      SINE_PEAK        = 131071;
	localparam longint      VAL_HI           = 64'sd2147483647;
	localparam longint      VAL_LO           = -64'sd2147483648;
	localparam longint      PEAK_SAMPLE      = 2147467263;      // full peak times full sine

	typedef struct packed {
		logic signed [VALUE_W-1:0] source_voltage;
		logic signed [VALUE_W-1:0] inductor_voltage;
		logic signed [VALUE_W-1:0] load_voltage;
		logic signed [VALUE_W-1:0] cap_voltage;
		logic signed [VALUE_W-1:0] input_current;
		logic signed [VALUE_W-1:0] load_current;
		logic signed [VALUE_W-1:0] cap_current;
		logic                      saturated;
	} step_result_t;

	typedef enum logic [1:0] {
		ROW_WRITE,   // register write
		ROW_STEP,    // step checked against the filter model
		ROW_KNOWN    // step with its result written out in the plan
	} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		reg_idx_t     idx;
		logic [31:0]  data;
		logic         rst;
		step_result_t known;
	} plan_row_t;

	typedef enum {
		SET_ALL_ZERO,
		SET_ALL_MAX,
		SET_MIXED
	} setting_kind_t;

	// Block ports; every input starts at a known value
	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	reg_idx_t                  cfg_index = REG_SOURCE_PEAK;
	logic [COEF_W-1:0]         cfg_wdata = '0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic                      restart   = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [VALUE_W-1:0] source_voltage;
	logic signed [VALUE_W-1:0] inductor_voltage;
	logic signed [VALUE_W-1:0] load_voltage;
	logic signed [VALUE_W-1:0] cap_voltage;
	logic signed [VALUE_W-1:0] input_current;
	logic signed [VALUE_W-1:0] load_current;
	logic signed [VALUE_W-1:0] cap_current;
	logic                      saturated;

	// Filter model: register copies, sine table and circuit state
	logic [63:0]  coef_val [8];
	int unsigned  quarter_sine [SINE_ENTRIES];
	logic [31:0]  f_phase;
	longint       f_iin;
	longint       f_vcap;
	longint       f_iload;

	step_result_t awaited_steps [$];
	plan_row_t    plan [$];

	// Bookkeeping
	int failures         = 0;
	int steps_sent       = 0;
	int results_checked  = 0;
	int restarts_sent    = 0;
	int clipped_steps    = 0;
	int settings_applied = 0;
	int burst_left       = 0;
	int hold_cycles_req  = 0;
	int quiet_cycles     = 0;
	bit block_busy       = 1'b0;

	rlc_filter_euler_step DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.restart          (restart),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.source_voltage   (source_voltage),
		.inductor_voltage (inductor_voltage),
		.load_voltage     (load_voltage),
		.cap_voltage      (cap_voltage),
		.input_current    (input_current),
		.load_current     (load_current),
		.cap_current      (cap_current),
		.saturated        (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Filter model
	// ---------------------------------------------------------------------

	// Fill the quarter-wave table: Horner Taylor series to x^13 in Q30,
	// then scale to the 17-bit full-scale sample with rounding.
	function automatic void build_quarter_sine();
		logic [63:0] x, x2, t, s, e;
		logic [63:0] divs [6];
		divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			x  = (QUARTER_TURN_Q30 * 64'(k)) / 64'(SINE_ENTRIES);
			x2 = (x * x) >> 30;
			t  = ONE_Q30;
			for (int d = 0; d < 6; d++) begin
				t = ONE_Q30 - ((x2 * t) >> 30) / divs[d];
			end
			s = (x * t) >> 30;
			e = (s * 64'(SINE_PEAK) + (64'd1 << 29)) >> 30;
			if (e > 64'(SINE_PEAK)) begin
				e = 64'(SINE_PEAK);
			end
			quarter_sine[k] = e[31:0];
		end
	endfunction

	// Top two phase bits pick the quadrant, the next bits the table entry;
	// the mirrored index past the end reads the full-scale peak.
	function automatic longint sine_sample(input logic [31:0] p);
		longint unsigned idx;
		longint unsigned j;
		longint          mag;
		idx = (64'(p[29:0]) * 64'(SINE_ENTRIES)) >> 30;
		j   = p[30] ? 64'(SINE_ENTRIES) - idx : idx;
		mag = (j >= SINE_ENTRIES) ? SINE_PEAK : longint'(quarter_sine[j]);
		return p[31] ? -mag : mag;
	endfunction

	// round(v * c / 2^sh) half away from zero, magnitude capped at 2^62
	function automatic longint scale_round(input longint v, input logic [63:0] c,
			input int unsigned sh);
		logic [63:0] m;
		logic [63:0] hi;
		logic [63:0] r;
		bit          neg;
		neg = (v < 0);
		if (neg) begin
			m = 64'd0 - 64'(v);
		end else begin
			m = 64'(v);
		end
		hi = (m >> 32) * c;
		if (hi >= (64'd1 << (30 + sh))) begin
			r = 64'd1 << 62;
		end else begin
			r = (hi << (32 - sh)) + (((m & 64'hFFFF_FFFF) * c + (64'd1 << (sh - 1))) >> sh);
		end
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint clip(input longint v, inout bit hit);
		if (v > VAL_HI) begin
			hit = 1'b1;
			return VAL_HI;
		end
		if (v < VAL_LO) begin
			hit = 1'b1;
			return VAL_LO;
		end
		return v;
	endfunction

	// Advance the circuit by one time step and return the word it reports.
	function automatic step_result_t advance_filter(input logic rst);
		longint       s, vs, drive, i_old, i_new, vli, ic, v_new, il_new;
		bit           hit;
		step_result_t r;
		if (rst) begin
			f_phase = '0;
			f_iin   = 0;
			f_vcap  = 0;
			f_iload = 0;
		end
		hit = 1'b0;
		s       = sine_sample(f_phase);
		f_phase = f_phase + coef_val[REG_PHASE_STEP][31:0];
		vs      = clip(scale_round(s, coef_val[REG_SOURCE_PEAK], 17), hit);
		drive   = vs - f_vcap;
		i_old   = f_iin;
		i_new   = clip(f_iin - scale_round(f_iin, coef_val[REG_INPUT_DECAY], 30)
			+ scale_round(drive, coef_val[REG_INPUT_GAIN], 30), hit);
		vli     = clip(scale_round(i_new - i_old, coef_val[REG_INPUT_RESISTANCE], 16)
			+ drive, hit);
		ic      = clip(i_new - f_iload, hit);
		v_new   = clip(f_vcap + scale_round(ic, coef_val[REG_CAP_GAIN], 30), hit);
		il_new  = clip(f_iload - scale_round(f_iload, coef_val[REG_LOAD_DECAY], 30)
			+ scale_round(v_new, coef_val[REG_LOAD_GAIN], 30), hit);
		f_iin   = i_new;
		f_vcap  = v_new;
		f_iload = il_new;
		r.source_voltage   = vs[31:0];
		r.inductor_voltage = vli[31:0];
		r.load_voltage     = v_new[31:0];
		r.cap_voltage      = v_new[31:0];
		r.input_current    = i_new[31:0];
		r.load_current     = il_new[31:0];
		r.cap_current      = ic[31:0];
		r.saturated        = hit;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic step_result_t known_step(input longint vs, input longint vli,
			input longint vcap, input longint iin, input longint iload, input longint icap,
			input logic sat);
		step_result_t r;
		r.source_voltage   = vs[31:0];
		r.inductor_voltage = vli[31:0];
		r.load_voltage     = vcap[31:0];
		r.cap_voltage      = vcap[31:0];
		r.input_current    = iin[31:0];
		r.load_current     = iload[31:0];
		r.cap_current      = icap[31:0];
		r.saturated        = sat;
		return r;
	endfunction

	function automatic void add_row(input row_kind_t kind, input reg_idx_t idx,
			input logic [31:0] data, input logic rst, input step_result_t known);
		plan_row_t row;
		row.kind  = kind;
		row.idx   = idx;
		row.data  = data;
		row.rst   = rst;
		row.known = known;
		plan.push_back(row);
	endfunction

	function automatic logic [31:0] pick_value(input reg_idx_t idx, input setting_kind_t kind);
		logic [31:0] v;
		int          roll;
		if (kind == SET_ALL_ZERO) begin
			return '0;
		end
		if (kind == SET_ALL_MAX) begin
			return '1;
		end
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			v = '0;
		end else if (roll == 1) begin
			v = '1;
		end else if (roll <= 3) begin
			v = $urandom;
		end else begin
			// realistic circuit: small step size against the time constants
			case (idx)
				REG_SOURCE_PEAK:      v = $urandom_range(32'h0001_0000, 32'h0400_0000);
				REG_PHASE_STEP:       v = $urandom_range(32'h0004_0000, 32'h1000_0000);
				REG_INPUT_RESISTANCE: v = $urandom_range(0, 32'h0010_0000);
				default:              v = $urandom_range(32'h0000_4000, 32'h0400_0000);
			endcase
		end
		// the 31-bit registers must drop the top bit of the write data
		if (idx == REG_SOURCE_PEAK || idx == REG_INPUT_RESISTANCE) begin
			v[31] = $urandom_range(0, 1);
		end
		return v;
	endfunction

	// Drop valid, let every awaited word drain out, then let the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (awaited_steps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		block_busy = 1'b0;
		burst_left = 0;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		if (block_busy) begin
			wait_idle();
		end
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		if (idx == REG_SOURCE_PEAK || idx == REG_INPUT_RESISTANCE) begin
			coef_val[idx] = {33'd0, data[30:0]};
		end else begin
			coef_val[idx] = {32'd0, data};
		end
	endtask

	task automatic close_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	task automatic apply_setting(input setting_kind_t kind);
		for (int r = 0; r <= REG_INPUT_RESISTANCE; r++) begin
			write_reg(reg_idx_t'(r), pick_value(reg_idx_t'(r), kind));
		end
		close_writes();
	endtask

	// Offer one step word; the sender runs in bursts with random gaps between.
	// Hold valid and payload until the word is taken, then log what it must produce.
	task automatic offer_step(input logic rst_bit, input bit typed, input step_result_t typed_res);
		int           gap;
		step_result_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 99) < 25) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		restart  <= rst_bit;
		do @(posedge clk); while (in_stall !== 1'b0);
		burst_left--;
		steps_sent++;
		if (rst_bit) begin
			restarts_sent++;
		end
		predicted = advance_filter(rst_bit);
		if (predicted.saturated) begin
			clipped_steps++;
		end
		awaited_steps.push_back(typed ? typed_res : predicted);
		block_busy = 1'b1;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			if (failures < ERROR_PRINTS) begin
				$error("%s: expected %0d (0x%08h), got %0d (0x%08h)", name,
					$signed(want), want, $signed(got), got);
			end
			failures++;
		end
	endtask

	// ---------------------------------------------------------------------
	// Result side: stall on a changing pattern; honor one long hold-off
	// ---------------------------------------------------------------------
	initial begin : result_side
		int hold_left;
		int mode_left;
		int stall_pct;
		hold_left = 0;
		mode_left = 0;
		stall_pct = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles_req != 0) begin
				hold_left       = hold_cycles_req;
				hold_cycles_req = 0;
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(40, 200);
				case ($urandom_range(0, 3))
					0:       stall_pct = 0;
					1:       stall_pct = 20;
					2:       stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Compare every accepted result word with the oldest awaited step.
	always @(posedge clk) begin : compare_results
		step_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (awaited_steps.size() == 0) begin
				if (failures < ERROR_PRINTS) begin
					$error("result word with no step outstanding");
				end
				failures++;
			end else begin
				want = awaited_steps.pop_front();
				results_checked++;
				check_field("source_voltage", want.source_voltage, source_voltage);
				check_field("inductor_voltage", want.inductor_voltage, inductor_voltage);
				check_field("load_voltage", want.load_voltage, load_voltage);
				check_field("cap_voltage", want.cap_voltage, cap_voltage);
				check_field("input_current", want.input_current, input_current);
				check_field("load_current", want.load_current, load_current);
				check_field("cap_current", want.cap_current, cap_current);
				check_field("saturated", {31'd0, want.saturated}, {31'd0, saturated});
			end
		end
	end

	// Give up when neither channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no handshake for %0d cycles, %0d results still awaited",
				quiet_cycles, awaited_steps.size());
			$display("rlc_filter_euler_step: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin : stimulus
		int           random_steps;
		int           phase_no;
		int           phase_len;
		setting_kind_t kind;
		step_result_t zero_step;

		build_quarter_sine();
		foreach (coef_val[r]) begin
			coef_val[r] = '0;
		end
		f_phase = '0;
		f_iin   = 0;
		f_vcap  = 0;
		f_iload = 0;
		zero_step = known_step(0, 0, 0, 0, 0, 0, 1'b0);

		// Directed plan.
		// All registers at reset: the filter stays at rest, with and without restart.
		add_row(ROW_KNOWN, REG_SOURCE_PEAK, '0, 1'b0, zero_step);
		add_row(ROW_KNOWN, REG_SOURCE_PEAK, '0, 1'b1, zero_step);
		// Full peak (top data bit dropped) and a quarter turn per step: walk the
		// four quadrant boundaries, including the mirrored peak entry.
		add_row(ROW_WRITE, REG_SOURCE_PEAK, 32'hFFFF_FFFF, 1'b0, '0);
		add_row(ROW_WRITE, REG_PHASE_STEP, 32'h4000_0000, 1'b0, '0);
		add_row(ROW_KNOWN, REG_SOURCE_PEAK, '0, 1'b1, zero_step);
		add_row(ROW_KNOWN, REG_SOURCE_PEAK, '0, 1'b0,
			known_step(PEAK_SAMPLE, PEAK_SAMPLE, 0, 0, 0, 0, 1'b0));
		add_row(ROW_KNOWN, REG_SOURCE_PEAK, '0, 1'b0, zero_step);
		add_row(ROW_KNOWN, REG_SOURCE_PEAK, '0, 1'b0,
			known_step(-PEAK_SAMPLE, -PEAK_SAMPLE, 0, 0, 0, 0, 1'b0));
		// Largest input gain: the input current clips high, holds, then clips low.
		add_row(ROW_WRITE, REG_INPUT_GAIN, 32'hFFFF_FFFF, 1'b0, '0);
		add_row(ROW_KNOWN, REG_SOURCE_PEAK, '0, 1'b1, zero_step);
		add_row(ROW_KNOWN, REG_SOURCE_PEAK, '0, 1'b0,
			known_step(PEAK_SAMPLE, PEAK_SAMPLE, 0, VAL_HI, 0, VAL_HI, 1'b1));
		add_row(ROW_KNOWN, REG_SOURCE_PEAK, '0, 1'b0,
			known_step(0, 0, 0, VAL_HI, 0, VAL_HI, 1'b0));
		add_row(ROW_KNOWN, REG_SOURCE_PEAK, '0, 1'b0,
			known_step(-PEAK_SAMPLE, -PEAK_SAMPLE, 0, VAL_LO, 0, VAL_LO, 1'b1));
		// A plausible circuit, with a restart in the middle of the run.
		add_row(ROW_WRITE, REG_SOURCE_PEAK, 32'h000A_0000, 1'b0, '0);
		add_row(ROW_WRITE, REG_PHASE_STEP, 32'h0100_0000, 1'b0, '0);
		add_row(ROW_WRITE, REG_INPUT_DECAY, 32'h0020_0000, 1'b0, '0);
		add_row(ROW_WRITE, REG_INPUT_GAIN, 32'h0100_0000, 1'b0, '0);
		add_row(ROW_WRITE, REG_CAP_GAIN, 32'h0040_0000, 1'b0, '0);
		add_row(ROW_WRITE, REG_LOAD_DECAY, 32'h0010_0000, 1'b0, '0);
		add_row(ROW_WRITE, REG_LOAD_GAIN, 32'h0080_0000, 1'b0, '0);
		add_row(ROW_WRITE, REG_INPUT_RESISTANCE, 32'h8001_8000, 1'b0, '0);
		add_row(ROW_STEP, REG_SOURCE_PEAK, '0, 1'b1, '0);
		add_row(ROW_STEP, REG_SOURCE_PEAK, '0, 1'b0, '0);
		add_row(ROW_STEP, REG_SOURCE_PEAK, '0, 1'b0, '0);
		add_row(ROW_STEP, REG_SOURCE_PEAK, '0, 1'b0, '0);
		add_row(ROW_STEP, REG_SOURCE_PEAK, '0, 1'b1, '0);
		add_row(ROW_STEP, REG_SOURCE_PEAK, '0, 1'b0, '0);
		// Every register at its top value: phase runs backward one LSB a step.
		for (int r = 0; r <= REG_INPUT_RESISTANCE; r++) begin
			add_row(ROW_WRITE, reg_idx_t'(r), 32'hFFFF_FFFF, 1'b0, '0);
		end
		add_row(ROW_STEP, REG_SOURCE_PEAK, '0, 1'b1, '0);
		for (int n = 0; n < 5; n++) begin
			add_row(ROW_STEP, REG_SOURCE_PEAK, '0, 1'b0, '0);
		end

		// Hold reset low at the start, then release it for good.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed plan.
		foreach (plan[n]) begin
			case (plan[n].kind)
				ROW_WRITE: begin
					write_reg(plan[n].idx, plan[n].data);
					if (n + 1 == plan.size() || plan[n + 1].kind != ROW_WRITE) begin
						close_writes();
					end
				end
				ROW_KNOWN: offer_step(plan[n].rst, 1'b1, plan[n].known);
				default:   offer_step(plan[n].rst, 1'b0, '0);
			endcase
		end

		// Random part: each phase drains the block, loads a new register setting
		// and runs a stretch of steps; the first phases use the extreme settings.
		random_steps = 0;
		phase_no     = 0;
		while (random_steps < RANDOM_STEPS) begin
			if (phase_no == 0) begin
				kind = SET_ALL_MAX;
			end else if (phase_no == 1) begin
				kind = SET_ALL_ZERO;
			end else begin
				kind = SET_MIXED;
			end
			apply_setting(kind);
			// back the block up once: the output holds off while words keep coming
			if (phase_no == 3) begin
				hold_cycles_req = HOLD_CYCLES;
			end
			phase_len = $urandom_range(60, 120);
			for (int n = 0; n < phase_len; n++) begin
				if (n == 0) begin
					offer_step($urandom_range(0, 1), 1'b0, '0);
				end else begin
					offer_step($urandom_range(0, 99) < 4, 1'b0, '0);
				end
			end
			random_steps += phase_len;
			phase_no++;
		end

		// Drain and let the block go quiet before the verdict.
		in_valid <= 1'b0;
		while (awaited_steps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d filter steps sent, %0d result words checked, %0d register settings",
			steps_sent, results_checked, settings_applied);
		$display("%0d steps began with restart, %0d steps clipped a value",
			restarts_sent, clipped_steps);
		if (failures == 0) begin
			$display("rlc_filter_euler_step: match");
		end else begin
			$display("rlc_filter_euler_step: mismatch");
		end
		$finish;
	end

endmodule
